@@ rtl/core/dda_pkg.sv @@
`default_nettype none

package dda_pkg;

    localparam int COORD_W   = 7;
    localparam int PIX_W     = 6;
    localparam int COLOR_W   = 24;
    localparam int RUN_LIMIT = 64;
    localparam int COUNT_W   = $clog2(RUN_LIMIT + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic run_step;
        logic flush_step;
    } t_ctrl;

    typedef struct packed {
        logic degen;
        logic div_done;
        logic run_done;
        logic run_stall;
        logic pend_valid;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/dda_ctrl.sv @@
`default_nettype none

module dda_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire dda_pkg::t_stat i_stat,
    output dda_pkg::t_ctrl     o_ctrl
);

    dda_pkg::t_state r_state;
    dda_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_ready = 1'b0;
        case (r_state)
            dda_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = dda_pkg::ST_DIV;
                end
            end
            dda_pkg::ST_DIV: begin
                // a single point needs no slope
                if (i_stat.degen) begin
                    n_state = dda_pkg::ST_RUN;
                end else begin
                    o_ctrl.div_step = 1'b1;
                    if (i_stat.div_done) begin
                        n_state = dda_pkg::ST_RUN;
                    end
                end
            end
            dda_pkg::ST_RUN: begin
                if (i_stat.run_done) begin
                    n_state = dda_pkg::ST_FLUSH;
                end else if (!i_stat.run_stall) begin
                    o_ctrl.run_step = 1'b1;
                end
            end
            dda_pkg::ST_FLUSH: begin
                // hold until the held pixel can go out marked last
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_ctrl.flush_step = 1'b1;
                    n_state           = dda_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/dda_datapath.sv @@
`default_nettype none

module dda_datapath #(
    parameter int CANVAS_WIDTH  = 64,
    parameter int CANVAS_HEIGHT = 64,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_start_x,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_start_y,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_end_x,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_end_y,
    input  wire logic [dda_pkg::COLOR_W-1:0]  i_line_color,
    input  wire dda_pkg::t_ctrl               i_ctrl,
    output dda_pkg::t_stat                    o_stat,
    input  wire logic                         i_ready,
    output logic                              o_valid,
    output logic [dda_pkg::PIX_W-1:0]         o_pixel_x,
    output logic [dda_pkg::PIX_W-1:0]         o_pixel_y,
    output logic [dda_pkg::COLOR_W-1:0]       o_pixel_color,
    output logic                              o_last_pixel
);

    localparam int CW     = dda_pkg::COORD_W;
    localparam int PW     = dda_pkg::PIX_W;
    localparam int ACC_W  = CW + FRAC_BITS;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int DCNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CW-1:0] W_LIM = CW'(CANVAS_WIDTH);
    localparam logic [CW-1:0] H_LIM = CW'(CANVAS_HEIGHT);
    localparam logic [dda_pkg::COUNT_W-1:0] CNT_LIM = dda_pkg::COUNT_W'(dda_pkg::RUN_LIMIT);

    // line setup from the input ports
    logic [CW-1:0] s_adx, s_ady, s_maj0, s_maj1, s_min0, s_min1, s_t_maj0, s_t_maj1;
    logic [CW-1:0] s_t_min0, s_t_min1, s_span_maj, s_span_min;
    logic          s_xmaj, s_degen, s_swap;

    always_comb begin
        s_adx      = (i_start_x > i_end_x) ? i_start_x - i_end_x : i_end_x - i_start_x;
        s_ady      = (i_start_y > i_end_y) ? i_start_y - i_end_y : i_end_y - i_start_y;
        s_xmaj     = s_adx > s_ady;
        s_degen    = (s_adx == '0) && (s_ady == '0);
        s_t_maj0   = s_xmaj ? i_start_x : i_start_y;
        s_t_maj1   = s_xmaj ? i_end_x   : i_end_y;
        s_t_min0   = s_xmaj ? i_start_y : i_start_x;
        s_t_min1   = s_xmaj ? i_end_y   : i_end_x;
        s_span_maj = s_xmaj ? s_adx : s_ady;
        s_span_min = s_xmaj ? s_ady : s_adx;
        s_swap     = s_t_maj0 > s_t_maj1;
        s_maj0     = s_swap ? s_t_maj1 : s_t_maj0;
        s_maj1     = s_swap ? s_t_maj0 : s_t_maj1;
        s_min0     = s_swap ? s_t_min1 : s_t_min0;
        s_min1     = s_swap ? s_t_min0 : s_t_min1;
    end

    // line state
    logic [CW:0]                   r_maj, n_maj, r_maj_end, n_maj_end;
    logic [ACC_W-1:0]              r_acc, n_acc;
    logic [Q_W-1:0]                r_quo, n_quo;
    logic [CW:0]                   r_rem, n_rem;
    logic [CW-1:0]                 r_div, n_div;
    logic [DCNT_W-1:0]             r_div_cnt, n_div_cnt;
    logic                          r_desc, n_desc, r_xmaj, n_xmaj, r_degen, n_degen;
    logic [dda_pkg::COLOR_W-1:0]   r_color, n_color;
    logic [dda_pkg::COUNT_W-1:0]   r_count, n_count;
    // held pixel and output register
    logic                          r_pend_valid, n_pend_valid;
    logic [PW-1:0]                 r_pend_x, n_pend_x, r_pend_y, n_pend_y;
    logic                          r_out_valid, n_out_valid;
    logic [PW-1:0]                 r_out_x, n_out_x, r_out_y, n_out_y;
    logic [dda_pkg::COLOR_W-1:0]   r_out_color, n_out_color;
    logic                          r_out_last, n_out_last;

    logic             c_ge;
    logic [CW:0]      c_diff;
    logic [CW-1:0]    c_minor, c_x, c_y;
    logic             c_ok, c_out_free;
    logic [ACC_W-1:0] c_slope;

    always_comb begin
        c_ge       = r_rem >= {1'b0, r_div};
        c_diff     = r_rem - {1'b0, r_div};
        c_minor    = r_acc[ACC_W-1:FRAC_BITS];
        c_x        = r_xmaj ? r_maj[CW-1:0] : c_minor;
        c_y        = r_xmaj ? c_minor : r_maj[CW-1:0];
        c_ok       = (c_x <= W_LIM) && (c_y <= H_LIM);
        c_out_free = !r_out_valid || i_ready;
        c_slope    = ACC_W'(r_quo);
    end

    always_comb begin
        o_stat.degen      = r_degen;
        o_stat.div_done   = r_div_cnt == DCNT_W'(FRAC_BITS);
        o_stat.run_done   = (r_maj == r_maj_end) || (r_count == CNT_LIM);
        o_stat.run_stall  = c_ok && r_pend_valid && !c_out_free;
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = c_out_free;
    end

    always_comb begin
        n_maj        = r_maj;
        n_maj_end    = r_maj_end;
        n_acc        = r_acc;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div        = r_div;
        n_div_cnt    = r_div_cnt;
        n_desc       = r_desc;
        n_xmaj       = r_xmaj;
        n_degen      = r_degen;
        n_color      = r_color;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_out_valid  = (r_out_valid && i_ready) ? 1'b0 : r_out_valid;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_color  = r_out_color;
        n_out_last   = r_out_last;

        if (i_ctrl.load) begin
            n_maj     = {1'b0, s_maj0};
            n_maj_end = {1'b0, s_maj1} + (CW + 1)'(s_degen);
            n_acc     = {s_min0, FRAC_BITS'(0)};
            n_quo     = '0;
            n_rem     = {1'b0, s_span_min};
            n_div     = s_span_maj;
            n_div_cnt = '0;
            n_desc    = s_min1 < s_min0;
            n_xmaj    = s_xmaj;
            n_degen   = s_degen;
            n_color   = i_line_color;
            n_count   = '0;
        end

        // restoring division, one quotient bit a step
        if (i_ctrl.div_step) begin
            n_quo     = {r_quo[Q_W-2:0], c_ge};
            n_rem     = {(c_ge ? c_diff[CW-1:0] : r_rem[CW-1:0]), 1'b0};
            n_div_cnt = r_div_cnt + DCNT_W'(1);
        end

        if (i_ctrl.run_step) begin
            n_maj = r_maj + (CW + 1)'(1);
            if (r_desc) begin
                n_acc = (r_acc > c_slope) ? r_acc - c_slope : '0;
            end else begin
                n_acc = r_acc + c_slope;
            end
            if (c_ok) begin
                // a new pixel proves the held one is not last: release it
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_pend_x;
                    n_out_y     = r_pend_y;
                    n_out_color = r_color;
                    n_out_last  = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_x     = (c_x == W_LIM) ? PW'(W_LIM - CW'(1)) : c_x[PW-1:0];
                n_pend_y     = (c_y == H_LIM) ? PW'(H_LIM - CW'(1)) : c_y[PW-1:0];
                n_count      = r_count + dda_pkg::COUNT_W'(1);
            end
        end

        if (i_ctrl.flush_step && r_pend_valid) begin
            n_out_valid  = 1'b1;
            n_out_x      = r_pend_x;
            n_out_y      = r_pend_y;
            n_out_color  = r_color;
            n_out_last   = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_div_cnt    <= '0;
            r_degen      <= 1'b0;
            r_maj        <= '0;
            r_maj_end    <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_count      <= n_count;
            r_div_cnt    <= n_div_cnt;
            r_degen      <= n_degen;
            r_maj        <= n_maj;
            r_maj_end    <= n_maj_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_desc      <= n_desc;
        r_xmaj      <= n_xmaj;
        r_color     <= n_color;
        r_pend_x    <= n_pend_x;
        r_pend_y    <= n_pend_y;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/core/dda_line_rasterizer.sv @@
// DDA line rasterizer.
// Input channel (i_valid / o_ready): one item is a line, two endpoints in
// canvas coordinates and a 24-bit color. Output channel (o_valid / i_ready):
// one item per pixel write, in drawing order; o_last_pixel marks the final
// pixel of a line. A line whose pixels all fall outside the canvas gives no
// items. Runs stop after 64 pixels.
// Per line: the line is accepted, the serial slope divider forms FRAC_BITS+1
// quotient bits (skipped for a single point), the stepper takes one
// major-axis step at a time, the end of the run is seen and the run closes.
// The divider and the stepper set the time from one accepted line to the
// next while the receiver keeps up.
// One pixel is held back until the next in-canvas pixel or the end of the
// run shows whether it is last, so the first pixel of a line enters the
// output register as the second is taken into the hold. A new line is taken
// once the previous run has closed, even while its last pixel still sits in
// the output register. A stalled receiver holds the output register and then the stepper.
// Reset (synchronous, active low) drops any line in progress and any
// pending pixel; the block then waits for a line.
`default_nettype none

module dda_line_rasterizer #(
    parameter int CANVAS_WIDTH  = 64,
    parameter int CANVAS_HEIGHT = 64,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_start_x,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_start_y,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_end_x,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_end_y,
    input  wire logic [dda_pkg::COLOR_W-1:0]  i_line_color,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [dda_pkg::PIX_W-1:0]         o_pixel_x,
    output logic [dda_pkg::PIX_W-1:0]         o_pixel_y,
    output logic [dda_pkg::COLOR_W-1:0]       o_pixel_color,
    output logic                              o_last_pixel
);

    dda_pkg::t_ctrl ctrl;
    dda_pkg::t_stat stat;

    dda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    dda_datapath #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_line_color  (i_line_color),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    // no pixel of an old line may still be held when a new line is taken
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !stat.pend_valid)
        else $error("pixel held while accepting a line");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(ctrl))
        else $error("more than one datapath command");

    a_step_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.run_step |-> !stat.run_done && !stat.run_stall)
        else $error("stepper advanced past end or under stall");

    // a closing pixel must never be overwritten before it is taken
    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_pixel && !i_ready |=> o_valid && o_last_pixel)
        else $error("last pixel lost under stall");

endmodule

`default_nettype wire

@@ test/dda_line_rasterizer_check.sv @@
`timescale 1ns / 100ps

module dda_line_rasterizer_check #(
    parameter int CANVAS_WIDTH  = 64,
    parameter int CANVAS_HEIGHT = 64,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_line_valid,
    input  wire logic                         i_line_ready,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_start_x,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_start_y,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_end_x,
    input  wire logic [dda_pkg::COORD_W-1:0]  i_end_y,
    input  wire logic [dda_pkg::COLOR_W-1:0]  i_line_color,
    input  wire logic                         i_pixel_valid,
    input  wire logic                         i_pixel_ready,
    input  wire logic [dda_pkg::PIX_W-1:0]    i_pixel_x,
    input  wire logic [dda_pkg::PIX_W-1:0]    i_pixel_y,
    input  wire logic [dda_pkg::COLOR_W-1:0]  i_pixel_color,
    input  wire logic                         i_last_pixel,
    output logic [31:0]                       o_fail_count,
    output logic [31:0]                       o_pixels_pending
);

    localparam int CW    = dda_pkg::COORD_W;
    localparam int PW    = dda_pkg::PIX_W;
    localparam int CLR_W = dda_pkg::COLOR_W;
    localparam int LIMIT = dda_pkg::RUN_LIMIT;

    typedef struct packed {
        logic [PW-1:0]    col;
        logic [PW-1:0]    row;
        logic [CLR_W-1:0] color;
        logic             last_flag;
    } t_pixel;

    t_pixel expected_pixels[$];
    int     mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @ %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Walk the major axis once, collecting in-canvas pixels, then queue them.
    task automatic predict_line(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                                input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                                input logic [CLR_W-1:0] color);
        logic [CW-1:0]  span_x, span_y, span_major, span_minor, min_a, min_b, swap_c;
        logic [CW:0]    maj_a, maj_b, major, swap_m, minor, px, py;
        logic           x_major, falling;
        logic [31:0]    slope, accum;
        logic [PW-1:0]  col [LIMIT];
        logic [PW-1:0]  row [LIMIT];
        t_pixel         next_pix;
        int             emitted, k;

        span_x  = (sx > ex) ? sx - ex : ex - sx;
        span_y  = (sy > ey) ? sy - ey : ey - sy;
        x_major = span_x > span_y;
        if (x_major) begin
            maj_a = (CW + 1)'(sx); maj_b = (CW + 1)'(ex); min_a = sy; min_b = ey;
            span_major = span_x; span_minor = span_y;
        end else begin
            maj_a = (CW + 1)'(sy); maj_b = (CW + 1)'(ey); min_a = sx; min_b = ex;
            span_major = span_y; span_minor = span_x;
        end
        if (maj_a > maj_b) begin
            swap_m = maj_a; maj_a = maj_b; maj_b = swap_m;
            swap_c = min_a; min_a = min_b; min_b = swap_c;
        end
        // single point: one pass of the stepper with a flat slope
        if (span_major == 0)
            maj_b = maj_a + 1'b1;
        falling = min_b < min_a;
        slope   = (span_major == 0) ? 32'd0 : (32'(span_minor) << FRAC_BITS) / 32'(span_major);
        accum   = 32'(min_a) << FRAC_BITS;
        emitted = 0;
        for (major = maj_a; major < maj_b && emitted < LIMIT; major++) begin
            minor = (CW + 1)'(accum >> FRAC_BITS);
            px    = x_major ? major : minor;
            py    = x_major ? minor : major;
            // drop pixels past the canvas, clamp those sitting on its edge
            if (px <= CANVAS_WIDTH && py <= CANVAS_HEIGHT) begin
                col[emitted] = (px == CANVAS_WIDTH)  ? PW'(CANVAS_WIDTH - 1)  : PW'(px);
                row[emitted] = (py == CANVAS_HEIGHT) ? PW'(CANVAS_HEIGHT - 1) : PW'(py);
                emitted++;
            end
            if (falling)
                accum = (accum > slope) ? accum - slope : 32'd0;
            else
                accum = accum + slope;
        end
        for (k = 0; k < emitted; k++) begin
            next_pix.col       = col[k];
            next_pix.row       = row[k];
            next_pix.color     = color;
            next_pix.last_flag = (k == emitted - 1);
            expected_pixels.push_back(next_pix);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n) begin
            if (i_pixel_valid === 1'b1 && i_pixel_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                                              i_pixel_x, i_pixel_y, i_pixel_color,
                                              i_last_pixel));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_x !== want.col)
                        report_mismatch($sformatf("pixel_x got %0d want %0d",
                                                  i_pixel_x, want.col));
                    if (i_pixel_y !== want.row)
                        report_mismatch($sformatf("pixel_y got %0d want %0d",
                                                  i_pixel_y, want.row));
                    if (i_pixel_color !== want.color)
                        report_mismatch($sformatf("pixel_color got %06h want %06h",
                                                  i_pixel_color, want.color));
                    if (i_last_pixel !== want.last_flag)
                        report_mismatch($sformatf("last_pixel got %0b want %0b at x=%0d y=%0d",
                                                  i_last_pixel, want.last_flag,
                                                  want.col, want.row));
                end
            end
            if (i_line_valid && i_line_ready === 1'b1)
                predict_line(i_start_x, i_start_y, i_end_x, i_end_y, i_line_color);
        end
        o_pixels_pending <= expected_pixels.size();
    end

endmodule

@@ test/dda_line_rasterizer_test.sv @@
`timescale 1ns / 100ps

module dda_line_rasterizer_test;

    localparam int CANVAS_WIDTH  = 64;
    localparam int CANVAS_HEIGHT = 64;
    localparam int FRAC_BITS     = 16;
    localparam int RANDOM_LINES  = 50;
    localparam int CW            = dda_pkg::COORD_W;
    localparam int PW            = dda_pkg::PIX_W;
    localparam int CLR_W         = dda_pkg::COLOR_W;

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_ready;
    logic [CW-1:0]        i_start_x    = '0;
    logic [CW-1:0]        i_start_y    = '0;
    logic [CW-1:0]        i_end_x      = '0;
    logic [CW-1:0]        i_end_y      = '0;
    logic [CLR_W-1:0]     i_line_color = '0;
    logic                 o_valid;
    logic                 i_ready      = 1'b0;
    logic [PW-1:0]        o_pixel_x;
    logic [PW-1:0]        o_pixel_y;
    logic [CLR_W-1:0]     o_pixel_color;
    logic                 o_last_pixel;

    logic [31:0]          fail_count;
    logic [31:0]          pixels_pending;
    int                   send_idle_pct = 6;
    int                   recv_idle_pct = 83;

    dda_line_rasterizer #(
        .CANVAS_WIDTH (CANVAS_WIDTH),
        .CANVAS_HEIGHT(CANVAS_HEIGHT),
        .FRAC_BITS    (FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_color(o_pixel_color),
        .o_last_pixel (o_last_pixel)
    );

    dda_line_rasterizer_check #(
        .CANVAS_WIDTH (CANVAS_WIDTH),
        .CANVAS_HEIGHT(CANVAS_HEIGHT),
        .FRAC_BITS    (FRAC_BITS)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_line_valid    (i_valid),
        .i_line_ready    (o_ready),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_line_color    (i_line_color),
        .i_pixel_valid   (o_valid),
        .i_pixel_ready   (i_ready),
        .i_pixel_x       (o_pixel_x),
        .i_pixel_y       (o_pixel_y),
        .i_pixel_color   (o_pixel_color),
        .i_last_pixel    (o_last_pixel),
        .o_fail_count    (fail_count),
        .o_pixels_pending(pixels_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Offer one line, idling first at the current rate, and hold it until taken.
    task automatic offer_line(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                              input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                              input logic [CLR_W-1:0] color);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_start_x    <= sx;
        i_start_y    <= sy;
        i_end_x      <= ex;
        i_end_y      <= ey;
        i_line_color <= color;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic drain_pixels();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pixels_pending != 0);
    endtask

    function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        return CW'(v);
    endfunction

    task automatic random_line();
        logic [CW-1:0] sx, sy, ex, ey;
        int            mode;
        mode = int'($urandom_range(99));
        if (mode < 50) begin
            sx = CW'($urandom_range(64)); sy = CW'($urandom_range(64));
            ex = CW'($urandom_range(64)); ey = CW'($urandom_range(64));
        end else if (mode < 65) begin
            sx = CW'($urandom_range(64)); sy = CW'($urandom_range(64));
            ex = near_coord(sx);          ey = near_coord(sy);
        end else if (mode < 80) begin
            sx = CW'($urandom_range(72, 56)); sy = CW'($urandom_range(72, 56));
            ex = CW'($urandom_range(72, 56)); ey = CW'($urandom_range(72, 56));
        end else if (mode < 90) begin
            sx = CW'($urandom_range(127)); sy = CW'($urandom_range(127));
            ex = CW'($urandom_range(127)); ey = CW'($urandom_range(127));
        end else begin
            sx = CW'($urandom_range(70)); sy = CW'($urandom_range(70));
            ex = sx;                      ey = sy;
        end
        offer_line(sx, sy, ex, ey, CLR_W'($urandom));
    endtask

    initial begin
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // points: origin, clamped corner, outside the canvas
        offer_line(7'd0,   7'd0,   7'd0,   7'd0,   24'h000000);
        offer_line(7'd64,  7'd64,  7'd64,  7'd64,  24'hFFFFFF);
        offer_line(7'd65,  7'd3,   7'd65,  7'd3,   24'h123456);
        offer_line(7'd127, 7'd127, 7'd127, 7'd127, 24'hFFFFFF);
        // axis-aligned runs, both directions
        offer_line(7'd0,   7'd5,   7'd63,  7'd5,   24'hAAAAAA);
        offer_line(7'd63,  7'd5,   7'd0,   7'd5,   24'h555555);
        offer_line(7'd7,   7'd0,   7'd7,   7'd64,  24'hFF0000);
        offer_line(7'd64,  7'd0,   7'd64,  7'd10,  24'h00FF00);
        offer_line(7'd60,  7'd64,  7'd64,  7'd64,  24'h0000FF);
        // equal spans pick y as major
        offer_line(7'd0,   7'd0,   7'd10,  7'd10,  24'hC0FFEE);
        offer_line(7'd10,  7'd0,   7'd0,   7'd10,  24'h0F0F0F);
        // falling minor axis
        offer_line(7'd0,   7'd20,  7'd5,   7'd0,   24'hF0F0F0);
        offer_line(7'd0,   7'd10,  7'd40,  7'd3,   24'h808080);
        offer_line(7'd0,   7'd127, 7'd127, 7'd0,   24'h7F7F7F);
        // runs that hit the 64-pixel limit
        offer_line(7'd0,   7'd0,   7'd127, 7'd0,   24'h010203);
        offer_line(7'd0,   7'd0,   7'd127, 7'd127, 24'hFEDCBA);
        // wholly and partly off the canvas
        offer_line(7'd70,  7'd70,  7'd100, 7'd90,  24'h333333);
        offer_line(7'd50,  7'd10,  7'd90,  7'd30,  24'hCCCCCC);
        // short and fractional slopes
        offer_line(7'd3,   7'd3,   7'd4,   7'd3,   24'h800001);
        offer_line(7'd0,   7'd0,   7'd1,   7'd3,   24'h7FFFFE);
        offer_line(7'd33,  7'd1,   7'd2,   7'd12,  24'h5A5A5A);
        drain_pixels();

        for (n = 0; n < RANDOM_LINES; n++) begin
            random_line();
            if ($urandom_range(99) < 5)
                drain_pixels();
        end
        drain_pixels();

        send_idle_pct =  83;
        recv_idle_pct <= 6;
        for (n = 0; n < RANDOM_LINES; n++)
            random_line();
        drain_pixels();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        for (n = 0; n < RANDOM_LINES; n++)
            random_line();
        drain_pixels();

        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pixels_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ dda_line_rasterizer.f @@
rtl/core/dda_pkg.sv
rtl/core/dda_ctrl.sv
rtl/core/dda_datapath.sv
rtl/core/dda_line_rasterizer.sv
test/dda_line_rasterizer_check.sv
test/dda_line_rasterizer_test.sv
